@@ rtl/bspq_pkg.sv @@
// Shared constants and codes for the bounded sorted priority queue.
`default_nettype none

package bspq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int PRIO_W = 8;
  localparam int ID_W   = 16;
  localparam int KEY_W  = PRIO_W + ID_W;
  localparam int CAP_W  = 5;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 56;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'b1;

endpackage

`default_nettype wire

@@ rtl/bounded_sorted_priority_queue_core.sv @@
// Bounded sorted priority queue: up to DEPTH (priority, id) messages held in a RAM in key
// order, one item (push, pop or query) at a time. A push scans the RAM from the front with
// one shared comparator (one entry per cycle) until it finds its slot, then moves the tail
// up one place (one entry per cycle) and writes the new key; a pop moves the entries behind
// the front down one place. Front and back are then read back from the RAM, which has a
// single port pair with a registered read. s_tready is high only in the idle state between
// items, so the next beat goes in at the earliest in the cycle after a result is registered;
// a finished result waits in the output register while the next item is taken, and a
// stalled m_tready holds the core until that register is free.
`default_nettype none

module bounded_sorted_priority_queue_core #(
  parameter int DEPTH = bspq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [bspq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bspq_pkg::CAP_W-1:0]        cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bspq_pkg::S_DATA_W-1:0]     s_tdata,  // msg_priority[7:0], msg_id[23:8]
  input  logic [bspq_pkg::ACT_W-1:0]        s_tuser,  // action[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bspq_pkg::M_DATA_W-1:0]     m_tdata   // front_priority[7:0], front_id[23:8],
                                                      // back_priority[31:24], back_id[47:32],
                                                      // count[52:48], is_empty[53],
                                                      // status[55:54]
);

  import bspq_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SHIFT_END,
    S_INSERT,
    S_FRONT,
    S_BACK,
    S_BACK_WAIT,
    S_DONE
  } state_t;

  state_t              state;
  logic [KEY_W-1:0]    key;
  logic [STAT_W-1:0]   status;
  logic [CW-1:0]       count;
  logic [CAP_W-1:0]    capacity;
  logic                descending;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       cidx;
  logic                rvalid;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       stop;
  logic                shift_up;
  logic [KEY_W-1:0]    front_q;
  logic [KEY_W-1:0]    back_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [KEY_W-1:0]    ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;
  logic                goes_ahead;

  logic [CMPW-1:0]     count_ext;
  logic [CW-1:0]       count_m1;
  logic [IW-1:0]       last;
  logic                full;
  logic [CNT_OUT_W-1:0] count_out;

  assign count_ext = CMPW'(count);
  assign count_m1  = count - 1'b1;
  assign last      = count_m1[IW-1:0];
  assign full      = (count >= CW'(DEPTH)) || (count_ext >= CMPW'(capacity));
  assign count_out = count_ext[CNT_OUT_W-1:0];
  assign s_tready  = (state == S_IDLE);

  bspq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bspq_cmp u_cmp (
    .key        (key),
    .entry      (ram_rdata),
    .descending (descending),
    .goes_ahead (goes_ahead)
  );

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = key;
    ram_raddr = idx;
    unique case (state)
      S_SHIFT, S_SHIFT_END: begin
        // move the entry read last cycle one place up or down
        ram_we    = rvalid;
        ram_waddr = shift_up ? (cidx + 1'b1) : (cidx - 1'b1);
        ram_wdata = ram_rdata;
      end
      S_INSERT: begin
        ram_we = 1'b1;
      end
      S_FRONT: begin
        ram_raddr = '0;
      end
      S_BACK: begin
        ram_raddr = last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      capacity   <= CAP_RESET;
      descending <= 1'b0;
      m_tvalid   <= 1'b0;
      rvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY:   capacity   <= cfg_data;
          CFG_DESCENDING: descending <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // a result loaded in S_DONE keeps m_tvalid high
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key    <= {s_tdata[PRIO_W-1:0], s_tdata[KEY_W-1:PRIO_W]};
            rvalid <= 1'b0;
            unique case (s_tuser)
              ACT_PUSH: begin
                idx <= '0;
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_FRONT;
                end else if (count == '0) begin
                  status <= ST_OK;
                  pos    <= '0;
                  state  <= S_INSERT;
                end else begin
                  status <= ST_OK;
                  state  <= S_SCAN;
                end
              end
              ACT_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_FRONT;
                end else if (count == CW'(1)) begin
                  status <= ST_OK;
                  count  <= count_m1;
                  state  <= S_FRONT;
                end else begin
                  status   <= ST_OK;
                  shift_up <= 1'b0;
                  idx      <= IW'(1);
                  stop     <= last;
                  state    <= S_SHIFT;
                end
              end
              default: begin
                status <= ST_OK;
                state  <= S_FRONT;
              end
            endcase
          end
        end

        S_SCAN: begin
          cidx <= idx;
          if (rvalid && goes_ahead) begin
            pos      <= cidx;
            idx      <= last;
            stop     <= cidx;
            shift_up <= 1'b1;
            rvalid   <= 1'b0;
            state    <= S_SHIFT;
          end else begin
            rvalid <= 1'b1;
            idx    <= idx + 1'b1;
            if (rvalid && (cidx == last)) begin
              pos   <= cidx + 1'b1;
              state <= S_INSERT;
            end
          end
        end

        S_SHIFT: begin
          rvalid <= 1'b1;
          cidx   <= idx;
          if (idx == stop) begin
            state <= S_SHIFT_END;
          end else if (shift_up) begin
            idx <= idx - 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_SHIFT_END: begin
          rvalid <= 1'b0;
          if (shift_up) begin
            state <= S_INSERT;
          end else begin
            count <= count_m1;
            state <= S_FRONT;
          end
        end

        S_INSERT: begin
          count <= count + 1'b1;
          state <= S_FRONT;
        end

        S_FRONT: begin
          if (count == '0) begin
            front_q <= '0;
            back_q  <= '0;
            state   <= S_DONE;
          end else begin
            state <= S_BACK;
          end
        end

        S_BACK: begin
          front_q <= ram_rdata;
          state   <= S_BACK_WAIT;
        end

        S_BACK_WAIT: begin
          back_q <= ram_rdata;
          state  <= S_DONE;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {status, (count == '0), count_out,
                         back_q[ID_W-1:0], back_q[KEY_W-1:ID_W],
                         front_q[ID_W-1:0], front_q[KEY_W-1:ID_W]};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bspq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bspq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/bspq_cmp.sv @@
// Key comparator: does the new key go in front of a held entry.
`default_nettype none

module bspq_cmp (
  input  logic [bspq_pkg::KEY_W-1:0] key,
  input  logic [bspq_pkg::KEY_W-1:0] entry,
  input  logic                       descending,
  output logic                       goes_ahead
);

  import bspq_pkg::*;

  // priority sits in the high bits, so a plain unsigned compare is the
  // lexicographic (priority, id) order
  always_comb begin
    if (descending) begin
      goes_ahead = (key >= entry);
    end else begin
      goes_ahead = (key < entry);
    end
  end

endmodule

`default_nettype wire

@@ rtl/bspq_checker.sv @@
// Port-level checks for the priority queue core, bound to the top level.
`default_nettype none

module bspq_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [bspq_pkg::M_DATA_W-1:0]     m_tdata
);

  import bspq_pkg::*;

  // the core is busy after taking an item; no new beat right behind an accepted one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken back to back");

  // an empty queue reports zero count and zero front and back
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[53]) |->
      (m_tdata[52:48] == '0) && (m_tdata[47:0] == '0))
    else $error("empty result with nonzero fields");

  // a refused pop only happens on an empty queue
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[55:54] == ST_EMPTY)) |-> m_tdata[53])
    else $error("pop refused on a non-empty queue");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind bounded_sorted_priority_queue_core bspq_checker u_bspq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/bounded_sorted_priority_queue_core_test.sv @@
// Self-checking testbench for the bounded sorted priority queue core.
`default_nettype none

module bounded_sorted_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bspq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 100;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;  // undefined code, acts as a query

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } queue_op_t;

  typedef struct {
    logic [PRIO_W-1:0]    front_prio;
    logic [ID_W-1:0]      front_id;
    logic [PRIO_W-1:0]    back_prio;
    logic [ID_W-1:0]      back_id;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 empty;
    logic [STAT_W-1:0]    stat;
  } queue_view_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CAP_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;  // msg_priority[7:0], msg_id[23:8]
  logic [ACT_W-1:0]      s_tuser = '0;  // action[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;  // front_priority, front_id, back_priority, back_id,
                                   // count, is_empty, status (lowest first)

  bounded_sorted_priority_queue_core #(.DEPTH(QDEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the queue contents and registers
  logic [KEY_W-1:0] held_keys [QDEPTH];
  int               held_len = 0;
  logic [CAP_W-1:0] cap_now = CAP_RESET;
  logic             desc_now = 1'b0;

  queue_op_t   ops_pending [$];
  queue_view_t views_due [$];
  logic        in_accepted = 1'b0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          fails = 0;
  int          cycles = 0;

  function automatic queue_view_t advance_queue(input logic [ACT_W-1:0] act,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [ID_W-1:0] id);
    queue_view_t      v;
    int               lim;
    int               pos;
    int               i;
    logic [KEY_W-1:0] key;
    v.stat = ST_OK;
    lim = (cap_now < QDEPTH) ? int'(cap_now) : QDEPTH;
    key = {prio, id};
    case (act)
      ACT_PUSH: begin
        if (held_len >= lim) begin
          v.stat = ST_FULL;
        end else begin
          pos = 0;
          // descending: slot before the first entry <= key; ascending: first entry > key
          while (pos < held_len &&
                 !(desc_now ? (key >= held_keys[pos]) : (key < held_keys[pos])))
            pos++;
          for (i = held_len; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
          held_len++;
        end
      end
      ACT_POP: begin
        if (held_len == 0) begin
          v.stat = ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < held_len; i++) held_keys[i] = held_keys[i+1];
          held_len--;
        end
      end
      default: ;
    endcase
    if (held_len > 0) begin
      {v.front_prio, v.front_id} = held_keys[0];
      {v.back_prio, v.back_id} = held_keys[held_len-1];
    end else begin
      {v.front_prio, v.front_id} = '0;
      {v.back_prio, v.back_id} = '0;
    end
    v.cnt = held_len[CNT_OUT_W-1:0];
    v.empty = (held_len == 0);
    return v;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // input acceptance feeds the shadow queue; output beats are checked in order
  always @(posedge clk) begin : monitor
    queue_view_t want;
    in_accepted <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready)
        views_due.push_back(advance_queue(s_tuser, s_tdata[7:0], s_tdata[23:8]));
      if (m_tvalid && m_tready) begin
        if (views_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) $error("result beat with nothing outstanding");
        end else begin
          want = views_due[0];
          views_due.delete(0);
          check_field("front_priority", int'(want.front_prio), int'(m_tdata[7:0]));
          check_field("front_id", int'(want.front_id), int'(m_tdata[23:8]));
          check_field("back_priority", int'(want.back_prio), int'(m_tdata[31:24]));
          check_field("back_id", int'(want.back_id), int'(m_tdata[47:32]));
          check_field("count", int'(want.cnt), int'(m_tdata[52:48]));
          check_field("is_empty", int'(want.empty), int'(m_tdata[53]));
          check_field("status", int'(want.stat), int'(m_tdata[55:54]));
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    queue_op_t op;
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
    if (!rst && (!s_tvalid || in_accepted)) begin
      if (ops_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        op = ops_pending[0];
        ops_pending.delete(0);
        s_tvalid <= 1'b1;
        s_tuser <= op.act;
        s_tdata <= {op.id, op.prio};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bounded_sorted_priority_queue_core");
      $finish;
    end
  end

  task automatic add_op(input logic [ACT_W-1:0] act, input logic [PRIO_W-1:0] prio,
                        input logic [ID_W-1:0] id);
    queue_op_t op;
    op.act = act;
    op.prio = prio;
    op.id = id;
    ops_pending.push_back(op);
  endtask

  // push_pct sets how hard a run leans toward filling the queue
  function automatic queue_op_t pick_op(input int push_pct);
    queue_op_t op;
    int        r;
    r = $urandom_range(99);
    if (r < push_pct) op.act = ACT_PUSH;
    else if (r < 85) op.act = ACT_POP;
    else if (r < 95) op.act = ACT_QUERY;
    else op.act = ACT_SPARE;
    if ($urandom_range(1)) begin
      op.prio = PRIO_W'($urandom);
      op.id = ID_W'($urandom);
    end else begin
      // narrow key set so that ties on priority and on the full key are common
      op.prio = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(3));
      op.id = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(3));
    end
    return op;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_CAPACITY) cap_now = val;
    else desc_now = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (!(ops_pending.size() == 0 && !s_tvalid && views_due.size() == 0));
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps [9];
    logic             descs [9];
    int               push_pct;
    caps = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd16, 5'd8, 5'd2, 5'd20};
    descs = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    src_idle_pct = 7;
    snk_idle_pct = 81;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty cases, extremes, equal keys in ascending order
    add_op(ACT_POP, 8'hFF, 16'hFFFF);
    add_op(ACT_QUERY, 8'h00, 16'h0000);
    add_op(ACT_SPARE, 8'hAA, 16'h5555);
    add_op(ACT_PUSH, 8'h80, 16'h1234);
    add_op(ACT_PUSH, 8'h00, 16'h0000);
    add_op(ACT_PUSH, 8'hFF, 16'hFFFF);
    add_op(ACT_PUSH, 8'h80, 16'h1234);
    add_op(ACT_PUSH, 8'h80, 16'h1235);
    add_op(ACT_POP, 8'h55, 16'hAAAA);
    add_op(ACT_QUERY, 8'hFF, 16'hFFFF);
    wait_idle();

    // capacity below the held count, then full and empty refusals
    write_reg(CFG_CAPACITY, 5'd3);
    write_reg(CFG_DESCENDING, 5'd1);
    add_op(ACT_PUSH, 8'h10, 16'h0010);
    add_op(ACT_POP, 8'h00, 16'h0000);
    add_op(ACT_PUSH, 8'h10, 16'h0010);
    add_op(ACT_POP, 8'h00, 16'h0000);
    add_op(ACT_PUSH, 8'h80, 16'h1234);
    add_op(ACT_PUSH, 8'h80, 16'h1234);
    add_op(ACT_POP, 8'h00, 16'h0000);
    add_op(ACT_POP, 8'h00, 16'h0000);
    add_op(ACT_POP, 8'h00, 16'h0000);
    add_op(ACT_POP, 8'h00, 16'h0000);
    wait_idle();

    write_reg(CFG_CAPACITY, 5'd0);
    add_op(ACT_PUSH, 8'h01, 16'h0001);
    add_op(ACT_QUERY, 8'h00, 16'h0000);
    wait_idle();

    // random runs; the queue contents carry over between settings
    for (int m = 0; m < 3; m++) begin
      src_idle_pct = (m == 0) ? 7 : (m == 1) ? 81 : 0;
      snk_idle_pct = (m == 0) ? 81 : (m == 1) ? 7 : 0;
      for (int k = 0; k < 3; k++) begin
        write_reg(CFG_CAPACITY, caps[m*3+k]);
        write_reg(CFG_DESCENDING, {4'd0, descs[m*3+k]});
        push_pct = 55;
        for (int n = 0; n < 61; n++) begin
          if (n % 20 == 0) push_pct = ($urandom_range(2) == 0) ? 30 :
                                      ($urandom_range(1) == 0) ? 55 : 80;
          ops_pending.push_back(pick_op(push_pct));
        end
        wait_idle();
      end
    end

    repeat (16) @(posedge clk);
    if (fails == 0) begin
      $display("PASS bounded_sorted_priority_queue_core");
    end else begin
      $display("FAIL bounded_sorted_priority_queue_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
